// File: src/gpr_pkg.sv
package gpr_pkg;

  localparam int PINS_PER_PORT = 16;

  // Operation codes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_EVENT = 2'd2;

  // Word offsets within a port
  localparam logic [3:0] W_MODER = 4'd0;
  localparam logic [3:0] W_IDR   = 4'd4;
  localparam logic [3:0] W_ODR   = 4'd5;
  localparam logic [3:0] W_BSRR  = 4'd6;

  localparam logic [1:0]  MODE_OUTPUT = 2'b01;
  localparam logic [31:0] IDR_RESET   = 32'h0000_FFFF;

  // Configuration register indexes
  localparam logic CFG_LINE_SEL = 1'b0;
  localparam logic CFG_EXTI_EN  = 1'b1;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  port;
    logic [3:0]  reg_word;
    logic [31:0] write_data;
    logic [3:0]  pin_index;
    logic        pressed;
  } gpr_in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        exti_valid;
    logic [3:0]  exti_line;
    logic        exti_level;
  } gpr_out_t;

  typedef struct packed {
    logic [63:0] line_sel;
    logic        exti_en;
  } gpr_cfg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_WR_MAIN,
    ST_WR_IDR,
    ST_DONE
  } gpr_state_t;

endpackage

// File: src/gpio_port_register_block_core.sv
// GPIO port register block: word reads and writes of each port's registers
// (MODER, IDR, ODR, BSRR and plain storage words) and active-low pin events
// with EXTI line forwarding. All register words sit in one RAM that is never
// read and written in the same cycle, so an item is handled as a sequence of
// RAM accesses: one read for a read, one write for a plain write, three reads
// and then the ODR/MODER and IDR write-back with the output loopback for a
// MODER/ODR/BSRR write, an IDR read-modify-write for a pin event, and no
// access for an absent port or word, an IDR write or an unused op. After
// reset the RAM is initialized one word per cycle, all NUM_PORTS *
// WORDS_PER_PORT words, before the first item is taken; config writes are
// taken throughout. The result sits in an output register, so the next item
// can start while it waits to be taken.
module gpio_port_register_block_core #(
  parameter int NUM_PORTS = 4,
  parameter int WORDS_PER_PORT = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gpr_pkg::gpr_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output gpr_pkg::gpr_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [63:0]       cfg_wdata
);

  import gpr_pkg::*;

  localparam int DEPTH = NUM_PORTS * WORDS_PER_PORT;
  localparam int ADDR_W = $clog2(DEPTH);

  gpr_cfg_t cfg_r;
  logic     out_valid_r;
  gpr_out_t out_data_r;
  logic     out_free, res_push;
  gpr_out_t res;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [31:0]       mem_wdata, mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_sel <= '0;
      cfg_r.exti_en  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LINE_SEL: cfg_r.line_sel <= cfg_wdata;
        CFG_EXTI_EN:  cfg_r.exti_en  <= cfg_wdata[0];
      endcase
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  gpr_seq #(
    .NUM_PORTS      (NUM_PORTS),
    .WORDS_PER_PORT (WORDS_PER_PORT)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .out_free  (out_free),
    .res_push  (res_push),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  gpr_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  a_exti_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.exti_valid) |-> (out_data.read_data == 32'd0))
    else $error("EXTI report carries read data");

endmodule

// File: src/gpr_mem.sv
module gpr_mem #(
  parameter int DEPTH = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [31:0]       wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [31:0]       rdata
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/gpr_seq.sv
module gpr_seq #(
  parameter int NUM_PORTS = 4,
  parameter int WORDS_PER_PORT = 16,
  localparam int DEPTH = NUM_PORTS * WORDS_PER_PORT,
  localparam int ADDR_W = $clog2(DEPTH),
  localparam int WIDX_W = $clog2(WORDS_PER_PORT)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gpr_pkg::gpr_in_t  in_data,
  input  gpr_pkg::gpr_cfg_t cfg,
  input  logic              out_free,
  output logic              res_push,
  output gpr_pkg::gpr_out_t res,
  output logic              mem_we,
  output logic [ADDR_W-1:0] mem_waddr,
  output logic [31:0]       mem_wdata,
  output logic              mem_re,
  output logic [ADDR_W-1:0] mem_raddr,
  input  logic [31:0]       mem_rdata
);

  import gpr_pkg::*;

  gpr_state_t  state_r, state_nxt;
  gpr_in_t     item_r;
  logic [31:0] moder_r, odr_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [WIDX_W-1:0] clr_word_r;

  logic in_port_ok, in_word_ok, in_loop_word;
  logic port_ok, word_ok, loop_word;
  logic [ADDR_W-1:0] base, addr_target, addr_moder, addr_odr, addr_idr;
  logic [31:0] moder_new, odr_new, idr_new, pin_bit;
  logic [15:0] loop_sel;
  logic [3:0]  line_port;
  logic        exti_hit;

  assign in_port_ok   = 32'(in_data.port) < NUM_PORTS;
  assign in_word_ok   = in_port_ok && (32'(in_data.reg_word) < WORDS_PER_PORT);
  assign in_loop_word = (in_data.reg_word == W_MODER) || (in_data.reg_word == W_ODR) ||
                        (in_data.reg_word == W_BSRR);

  assign port_ok   = 32'(item_r.port) < NUM_PORTS;
  assign word_ok   = port_ok && (32'(item_r.reg_word) < WORDS_PER_PORT);
  assign loop_word = (item_r.reg_word == W_MODER) || (item_r.reg_word == W_ODR) ||
                     (item_r.reg_word == W_BSRR);

  assign base        = ADDR_W'(32'(item_r.port) * WORDS_PER_PORT);
  assign addr_target = base + ADDR_W'(item_r.reg_word);
  assign addr_moder  = base + ADDR_W'(W_MODER);
  assign addr_odr    = base + ADDR_W'(W_ODR);
  assign addr_idr    = base + ADDR_W'(W_IDR);

  // updated MODER/ODR of a loopback write; mem_rdata holds IDR by then
  always_comb begin
    moder_new = (item_r.reg_word == W_MODER) ? item_r.write_data : moder_r;
    if (item_r.reg_word == W_ODR) begin
      odr_new = item_r.write_data;
    end else if (item_r.reg_word == W_BSRR) begin
      // set wins over reset
      odr_new = (odr_r & ~{16'b0, item_r.write_data[31:16]}) |
                {16'b0, item_r.write_data[15:0]};
    end else begin
      odr_new = odr_r;
    end
    for (int p = 0; p < PINS_PER_PORT; p++) begin
      loop_sel[p] = (moder_new[2*p +: 2] == MODE_OUTPUT);
    end
    pin_bit = 32'd1 << item_r.pin_index;
    if (item_r.op == OP_EVENT) begin
      idr_new = item_r.pressed ? (mem_rdata & ~pin_bit) : (mem_rdata | pin_bit);
    end else begin
      idr_new = (mem_rdata & ~{16'b0, loop_sel}) | (odr_new & {16'b0, loop_sel});
    end
  end

  assign line_port = cfg.line_sel[{item_r.pin_index, 2'b00} +: 4];
  assign exti_hit  = (item_r.op == OP_EVENT) && port_ok && cfg.exti_en &&
                     (line_port == 4'(item_r.port));

  always_comb begin
    res.read_data  = ((item_r.op == OP_READ) && word_ok) ? mem_rdata : 32'd0;
    res.exti_valid = exti_hit;
    res.exti_line  = exti_hit ? item_r.pin_index : 4'd0;
    res.exti_level = exti_hit && !item_r.pressed;
  end

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    res_push  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = addr_target;
    mem_wdata = item_r.write_data;
    mem_re    = 1'b0;
    mem_raddr = addr_moder;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = (32'(clr_word_r) == 32'(W_IDR)) ? IDR_RESET : 32'd0;
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (in_data.op)
            OP_READ:  state_nxt = in_word_ok ? ST_RD0 : ST_DONE;
            OP_WRITE: begin
              if (!in_word_ok || in_data.reg_word == W_IDR) begin
                state_nxt = ST_DONE;
              end else if (in_loop_word) begin
                state_nxt = ST_RD0;
              end else begin
                state_nxt = ST_WR_MAIN;
              end
            end
            OP_EVENT: state_nxt = in_port_ok ? ST_RD2 : ST_DONE;
            default:  state_nxt = ST_DONE;
          endcase
        end
      end
      ST_RD0: begin
        mem_re = 1'b1;
        if (item_r.op == OP_READ) begin
          mem_raddr = addr_target;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_RD1;
        end
      end
      ST_RD1: begin
        mem_re    = 1'b1;
        mem_raddr = addr_odr;
        state_nxt = ST_RD2;
      end
      ST_RD2: begin
        mem_re    = 1'b1;
        mem_raddr = addr_idr;
        state_nxt = (item_r.op == OP_EVENT) ? ST_WR_IDR : ST_WR_MAIN;
      end
      ST_WR_MAIN: begin
        // BSRR word itself is never stored: it stays at its reset value of zero
        mem_we = 1'b1;
        if (item_r.reg_word == W_BSRR) begin
          mem_waddr = addr_odr;
          mem_wdata = odr_new;
        end
        state_nxt = loop_word ? ST_WR_IDR : ST_DONE;
      end
      ST_WR_IDR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_idr;
        mem_wdata = idr_new;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          res_push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      clr_word_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        clr_word_r <= (32'(clr_word_r) == WORDS_PER_PORT - 1) ? '0 : clr_word_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      item_r <= in_data;
    end
    if (state_r == ST_RD1) begin
      moder_r <= mem_rdata;
    end
    if (state_r == ST_RD2) begin
      odr_r <= mem_rdata;
    end
  end

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> in_stall)
    else $error("input accepted during memory clear");

  a_single_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_re && mem_we))
    else $error("read and write issued in the same cycle");

  a_event_writes_idr: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.op == OP_EVENT && in_port_ok)
      |-> ##2 (mem_we && mem_waddr == addr_idr))
    else $error("pin event did not update IDR");

endmodule

// File: sim/tb_gpio_port_register_block_core.sv
`timescale 1ns / 100ps

module tb_gpio_port_register_block_core;
  import gpr_pkg::*;

  localparam int NUM_PORTS      = 4;
  localparam int WORDS_PER_PORT = 16;
  localparam int NUM_WORDS      = NUM_PORTS * WORDS_PER_PORT;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES  = 10;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  gpr_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  gpr_out_t    out_data;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_LINE_SEL;
  logic [63:0] cfg_wdata = '0;

  // shadow copy of the register file and the EXTI routing
  logic [31:0] port_regs [NUM_WORDS];
  logic [63:0] line_sel_model;
  logic        exti_en_model;

  gpr_out_t pending_responses [$];
  gpr_out_t oldest_response;
  int       error_count = 0;
  int       burst_left = 8;
  int       idle_cycles = 0;

  // receiver stall pattern
  int          hold_reqs = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          stall_seg_left = 0;
  int          stall_phase = 0;
  stall_kind_t stall_mode = STALL_NONE;

  gpio_port_register_block_core #(
    .NUM_PORTS(NUM_PORTS),
    .WORDS_PER_PORT(WORDS_PER_PORT)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void reset_model();
    for (int i = 0; i < NUM_WORDS; i++) begin
      port_regs[i] = (i[3:0] == W_IDR) ? IDR_RESET : '0;
    end
    line_sel_model = '0;
    exti_en_model = 1'b1;
  endfunction

  // Applies one item to the shadow state and returns the response it causes.
  function automatic gpr_out_t gpio_response(input gpr_in_t it);
    gpr_out_t    r;
    logic [5:0]  base;
    logic [31:0] odr;
    logic [31:0] out_pins;
    r = '0;
    base = {it.port, 4'd0};
    case (it.op)
      OP_READ: begin
        r.read_data = port_regs[{it.port, it.reg_word}];
      end
      OP_WRITE: begin
        if (it.reg_word == W_BSRR) begin
          odr = port_regs[base + W_ODR];
          port_regs[base + W_ODR] = (odr & ~{16'h0, it.write_data[31:16]})
                                    | {16'h0, it.write_data[15:0]};
          port_regs[base + W_BSRR] = '0;
        end else if (it.reg_word != W_IDR) begin
          port_regs[{it.port, it.reg_word}] = it.write_data;
        end
        if (it.reg_word == W_MODER || it.reg_word == W_ODR || it.reg_word == W_BSRR) begin
          // output-mode pins read back what ODR drives
          out_pins = '0;
          for (int p = 0; p < PINS_PER_PORT; p++) begin
            out_pins[p] = (port_regs[base + W_MODER][2*p +: 2] == MODE_OUTPUT);
          end
          port_regs[base + W_IDR] = (port_regs[base + W_IDR] & ~out_pins)
                                    | (port_regs[base + W_ODR] & out_pins);
        end
      end
      OP_EVENT: begin
        port_regs[base + W_IDR][it.pin_index] = ~it.pressed;
        if (exti_en_model && line_sel_model[4*it.pin_index +: 4] == {2'b00, it.port}) begin
          r.exti_valid = 1'b1;
          r.exti_line  = it.pin_index;
          r.exti_level = ~it.pressed;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic gpr_in_t make_item(input logic [1:0] op, input logic [1:0] port,
                                        input logic [3:0] word, input logic [31:0] data,
                                        input logic [3:0] pin, input logic pressed);
    gpr_in_t it;
    it.op = op;
    it.port = port;
    it.reg_word = word;
    it.write_data = data;
    it.pin_index = pin;
    it.pressed = pressed;
    return it;
  endfunction

  function automatic gpr_in_t random_gpio_item();
    gpr_in_t it;
    int      pick;
    it.port = 2'($urandom_range(0, 3));
    it.pin_index = 4'($urandom_range(0, 15));
    it.pressed = 1'($urandom_range(0, 1));
    it.write_data = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 30) it.op = OP_READ;
    else if (pick < 60) it.op = OP_WRITE;
    else if (pick < 96) it.op = OP_EVENT;
    else it.op = OP_UNUSED;
    // mostly the functional words, some plain storage
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1: it.reg_word = W_MODER;
      2, 3: it.reg_word = W_IDR;
      4, 5: it.reg_word = W_ODR;
      6, 7: it.reg_word = W_BSRR;
      default: it.reg_word = 4'($urandom_range(0, 15));
    endcase
    if (it.reg_word == W_MODER && $urandom_range(0, 1) == 1) begin
      it.write_data = it.write_data & 32'h5555_5555;
    end else if ($urandom_range(0, 15) == 0) begin
      it.write_data = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
    end
    return it;
  endfunction

  // Offers one item, waits for its transfer, then idles between bursts.
  task automatic send_item(input gpr_in_t it);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    pending_responses.push_back(gpio_response(it));
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 7) == 0 ? $urandom_range(10, 30) : $urandom_range(1, 5))
        @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
    end
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_item(random_gpio_item());
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg_reg(input logic idx, input logic [63:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_LINE_SEL) line_sel_model = value;
    else exti_en_model = value[0];
    @(posedge clk);
  endtask

  task automatic test_reset_values();
    for (int p = 0; p < NUM_PORTS; p++) begin
      send_item(make_item(OP_READ, 2'(p), W_IDR, '0, '0, 1'b0));
    end
    send_item(make_item(OP_READ, 2'd3, W_MODER, '0, '0, 1'b0));
  endtask

  task automatic test_register_access();
    send_item(make_item(OP_WRITE, 2'd0, W_MODER, 32'h5555_5555, '0, 1'b0));
    send_item(make_item(OP_WRITE, 2'd0, W_ODR, 32'hFFFF_0000, '0, 1'b0));
    send_item(make_item(OP_READ, 2'd0, W_IDR, '0, '0, 1'b0));
    // pins named in both halves of BSRR end up set
    send_item(make_item(OP_WRITE, 2'd0, W_BSRR, 32'h00FF_0F0F, '0, 1'b0));
    send_item(make_item(OP_READ, 2'd0, W_ODR, '0, '0, 1'b0));
    send_item(make_item(OP_READ, 2'd0, W_BSRR, '0, '0, 1'b0));
    // IDR is read-only
    send_item(make_item(OP_WRITE, 2'd1, W_IDR, 32'h0, '0, 1'b0));
    send_item(make_item(OP_READ, 2'd1, W_IDR, '0, '0, 1'b0));
    send_item(make_item(OP_WRITE, 2'd3, 4'd15, 32'hFFFF_FFFF, '0, 1'b0));
    send_item(make_item(OP_READ, 2'd3, 4'd15, '0, '0, 1'b0));
  endtask

  task automatic test_pin_events();
    send_item(make_item(OP_EVENT, 2'd0, '0, '0, 4'd0, 1'b1));
    send_item(make_item(OP_EVENT, 2'd0, '0, '0, 4'd15, 1'b0));
    send_item(make_item(OP_EVENT, 2'd1, '0, '0, 4'd7, 1'b1));
    // event on an output pin changes IDR until the next loopback
    send_item(make_item(OP_EVENT, 2'd0, '0, '0, 4'd3, 1'b1));
    send_item(make_item(OP_READ, 2'd0, W_IDR, '0, '0, 1'b0));
    send_item(make_item(OP_UNUSED, 2'd3, 4'hF, 32'hFFFF_FFFF, 4'hF, 1'b1));
  endtask

  task automatic test_config_sweep();
    logic [63:0] sel;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: sel = 64'h0;
        1: sel = 64'hFFFF_FFFF_FFFF_FFFF;
        2: sel = 64'h3210_3210_3210_3210;
        3: begin
          for (int n = 0; n < 16; n++) sel[4*n +: 4] = 4'($urandom_range(0, 3));
        end
        4: sel = {$urandom, $urandom};
        default: sel = 64'h1111_1111_1111_1111;
      endcase
      wait_drained();
      write_cfg_reg(CFG_LINE_SEL, sel);
      write_cfg_reg(CFG_EXTI_EN, (phase == 2) ? 64'h0 : 64'h1);
      send_random(120);
    end
  endtask

  task automatic test_random_traffic();
    send_random(400);
    // sender pauses until every response is back
    wait_drained();
    send_random(400);
  endtask

  task automatic test_backpressure();
    wait_drained();
    hold_reqs <= hold_reqs + 1;
    send_random(150);
  endtask

  // receiver: random stall patterns plus requested long hold-offs
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (stall_seg_left == 0) begin
      stall_mode = stall_kind_t'($urandom_range(0, 3));
      stall_seg_left = $urandom_range(20, 200);
    end else begin
      stall_seg_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_NONE: out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
        default: out_stall <= (stall_phase % 8 < 2);
      endcase
    end
    stall_phase++;
  end

  // response checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_responses.size() == 0) begin
        $error("unexpected output transfer: %p", out_data);
        error_count++;
      end else begin
        oldest_response = pending_responses.pop_front();
        if (out_data.read_data !== oldest_response.read_data) begin
          $error("read_data: expected %h, got %h", oldest_response.read_data,
                 out_data.read_data);
          error_count++;
        end
        if (out_data.exti_valid !== oldest_response.exti_valid) begin
          $error("exti_valid: expected %b, got %b", oldest_response.exti_valid,
                 out_data.exti_valid);
          error_count++;
        end
        if (out_data.exti_line !== oldest_response.exti_line) begin
          $error("exti_line: expected %0d, got %0d", oldest_response.exti_line,
                 out_data.exti_line);
          error_count++;
        end
        if (out_data.exti_level !== oldest_response.exti_level) begin
          $error("exti_level: expected %b, got %b", oldest_response.exti_level,
                 out_data.exti_level);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    reset_model();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_register_access();
    test_pin_events();
    test_config_sweep();
    test_random_traffic();
    test_backpressure();
    wait_drained();
    if (pending_responses.size() != 0) begin
      $error("%0d responses never arrived", pending_responses.size());
      error_count++;
    end
    if (error_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

// File: gpio_port_register_block_core.f
src/gpr_pkg.sv
src/gpr_mem.sv
src/gpr_seq.sv
src/gpio_port_register_block_core.sv
sim/tb_gpio_port_register_block_core.sv
